// ===== rtl/core/dihedral_conformation_histogram_assert.svh =====
// ----------------------------------------------------------------------------
// Dihedral conformation histogram assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef DIHEDRAL_CONFORMATION_HISTOGRAM_ASSERT_SVH
`define DIHEDRAL_CONFORMATION_HISTOGRAM_ASSERT_SVH

// same-cycle implication
`define DCH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DCH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dch_pkg.sv =====
// ----------------------------------------------------------------------------
// Dihedral conformation histogram package
// Field widths, codes, controller/datapath structs and centre tables.
// ----------------------------------------------------------------------------
package dch_pkg;

    localparam int ANGLE_W   = 16;
    localparam int MULT_W    = 3;
    localparam int EIDX_W    = 6;
    localparam int STAT_W    = 3;
    localparam int OIDX_W    = 6;
    localparam int FREQ_W    = 32;
    localparam int OCODE_W   = 24;
    localparam int USED_W    = 7;
    localparam int DIGIT_W   = 3;
    localparam int CFG_W     = 4;
    localparam int CFGI_W    = 1;
    localparam int NCENT_MAX = 6;
    localparam int MSEL_W    = 2;

    localparam logic [CFGI_W-1:0] REG_NUM_DIHEDRALS = 1'b0;
    localparam logic [CFGI_W-1:0] REG_MULT_OVERRIDE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_MATCHED    = 3'd0,
        ST_INSERTED   = 3'd1,
        ST_UNASSIGNED = 3'd2,
        ST_FULL       = 3'd3,
        ST_BAD_MULT   = 3'd4,
        ST_VALID      = 3'd5,
        ST_EMPTY      = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        A_INPUT,
        A_LATCH,
        A_ISSUE,
        A_HIT
    } t_asel;

    typedef struct packed {
        logic    sample;
        logic    read_start;
        logic    search;
        t_asel   asel;
        logic    load;
        t_status status;
        logic    wr_hit;
        logic    wr_new;
    } t_cmd;

    typedef struct packed {
        logic frame_end;
        logic frame_bad;
        logic frame_unasg;
        logic key_bad;
        logic rd_hit;
        logic hit;
        logic exhausted;
        logic full;
    } t_stat;

    function automatic logic mult_valid(input logic [MULT_W-1:0] m);
        return (m == 3'd2) || (m == 3'd3) || (m == 3'd4) || (m == 3'd6);
    endfunction

    function automatic logic [MSEL_W-1:0] mult_sel(input logic [MULT_W-1:0] m);
        logic [MSEL_W-1:0] s;
        case (m)
            3'd3:    s = 2'd1;
            3'd4:    s = 2'd2;
            3'd6:    s = 2'd3;
            default: s = 2'd0;
        endcase
        return s;
    endfunction

    function automatic logic [DIGIT_W-1:0] n_centers(input logic [MSEL_W-1:0] s);
        logic [DIGIT_W-1:0] n;
        case (s)
            2'd1:    n = 3'd3;
            2'd2:    n = 3'd4;
            2'd3:    n = 3'd6;
            default: n = 3'd2;
        endcase
        return n;
    endfunction

    // largest distance still assigned, plus one
    function automatic logic [ANGLE_W-1:0] thresh(input logic [MSEL_W-1:0] s);
        logic [ANGLE_W-1:0] t;
        case (s)
            2'd1:    t = 16'd10923;
            2'd2:    t = 16'd8192;
            2'd3:    t = 16'd5462;
            default: t = 16'd16384;
        endcase
        return t;
    endfunction

    function automatic logic [ANGLE_W-1:0] center(input logic [MSEL_W-1:0] s,
                                                  input logic [DIGIT_W-1:0] k);
        logic [ANGLE_W-1:0] c;
        c = '0;
        case (s)
            2'd0: begin
                case (k)
                    3'd0:    c = 16'd16384;
                    3'd1:    c = 16'd49152;
                    default: c = '0;
                endcase
            end
            2'd1: begin
                case (k)
                    3'd0:    c = 16'd10923;
                    3'd1:    c = 16'd32768;
                    3'd2:    c = 16'd54613;
                    default: c = '0;
                endcase
            end
            2'd2: begin
                case (k)
                    3'd0:    c = 16'd8192;
                    3'd1:    c = 16'd24576;
                    3'd2:    c = 16'd40960;
                    3'd3:    c = 16'd57344;
                    default: c = '0;
                endcase
            end
            default: begin
                case (k)
                    3'd0:    c = 16'd5461;
                    3'd1:    c = 16'd16384;
                    3'd2:    c = 16'd27307;
                    3'd3:    c = 16'd38229;
                    3'd4:    c = 16'd49152;
                    3'd5:    c = 16'd60075;
                    default: c = '0;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/dch_if.sv =====
// ----------------------------------------------------------------------------
// Dihedral conformation histogram stream interfaces
// Request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dch_in_if import dch_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [ANGLE_W-1:0]  angle;
    logic [ANGLE_W-1:0]  phase;
    logic [MULT_W-1:0]   multiplicity;
    logic [EIDX_W-1:0]   entry_index;

    modport source (
        output valid, req_type, angle, phase, multiplicity, entry_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, angle, phase, multiplicity, entry_index,
        output ready
    );
endinterface

interface dch_out_if import dch_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [OIDX_W-1:0]   cluster_index;
    logic [FREQ_W-1:0]   frequency;
    logic [OCODE_W-1:0]  minima_code;
    logic [USED_W-1:0]   used_entries;

    modport source (
        output valid, status, cluster_index, frequency, minima_code, used_entries,
        input  ready
    );
    modport sink (
        input  valid, status, cluster_index, frequency, minima_code, used_entries,
        output ready
    );
endinterface

// ===== rtl/core/dihedral_conformation_histogram.sv =====
// ----------------------------------------------------------------------------
// Dihedral conformation histogram
// Frames of dihedral samples classified into minima codes and counted.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries requests: a dihedral sample (req_type 0) or a table readout
//   (req_type 1). o_out returns at most one result per request. i_cfg_we
//   writes num_dihedrals (index 0) or mult_override (index 1); the user must
//   do so only while idle, the block itself does not enforce it. A sample
//   that does not end a frame gives no result. A frame-ending sample with no
//   bad multiplicity or unassigned dihedral in its frame starts a search
//   that walks the used entries one per cycle out of the code memory until
//   the first match or the last used entry; the result is then registered,
//   and the next request is taken once it is loaded. Other frame-ending
//   samples give an unassigned or bad-multiplicity status. A readout makes
//   one memory read. Reset empties the table and the frame in progress and
//   sets num_dihedrals to 1, mult_override to 0; no clearing pass is needed.
//   While o_out is stalled the result register holds; samples that end no
//   frame are still taken, and a request with a result is taken but its
//   result waits until the register is free.
// ----------------------------------------------------------------------------
module dihedral_conformation_histogram import dch_pkg::*; #(
    parameter int MAX_DIHEDRALS = 8,
    parameter int TABLE_ENTRIES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFGI_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    dch_in_if.sink            i_in,
    dch_out_if.source         o_out
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;
    logic  out_valid;

    dch_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_in_req_type (i_in.req_type),
        .o_in_ready    (in_ready),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (out_valid),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    dch_dp #(
        .MAX_DIHEDRALS (MAX_DIHEDRALS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_angle         (i_in.angle),
        .i_phase         (i_in.phase),
        .i_multiplicity  (i_in.multiplicity),
        .i_entry_index   (i_in.entry_index),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_status        (o_out.status),
        .o_cluster_index (o_out.cluster_index),
        .o_frequency     (o_out.frequency),
        .o_minima_code   (o_out.minima_code),
        .o_used_entries  (o_out.used_entries)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

// ===== rtl/core/dch_classify.sv =====
// ----------------------------------------------------------------------------
// Dihedral classifier
// Nearest centre of the selected multiplicity and acceptance window test.
// ----------------------------------------------------------------------------
module dch_classify import dch_pkg::*; (
    input  logic [ANGLE_W-1:0] i_diff,
    input  logic [MSEL_W-1:0]  i_sel,
    output logic [DIGIT_W-1:0] o_digit,
    output logic               o_assigned
);

    always_comb begin
        logic [ANGLE_W-1:0] best;
        logic [ANGLE_W-1:0] c;
        logic [ANGLE_W-1:0] span;
        best    = '1;
        o_digit = '0;
        for (int k = 0; k < NCENT_MAX; k++) begin
            c    = center(i_sel, DIGIT_W'(k));
            span = (i_diff > c) ? (i_diff - c) : (c - i_diff);
            // strict compare: lowest index wins a tie
            if ((DIGIT_W'(k) < n_centers(i_sel)) && (span < best)) begin
                best    = span;
                o_digit = DIGIT_W'(k);
            end
        end
        o_assigned = (best < thresh(i_sel));
    end

endmodule

// ===== rtl/core/dch_ctrl.sv =====
// ----------------------------------------------------------------------------
// Dihedral histogram controller
// Sequences samples, readouts, table search and result loading.
// ----------------------------------------------------------------------------
module dch_ctrl import dch_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_req_type,
    output logic  o_in_ready,
    input  logic  i_out_ready,
    output logic  o_out_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DROP,
        S_SEARCH,
        S_MATCH,
        S_INSERT,
        S_FULL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   accept;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.asel   = A_INPUT;
        o_cmd.status = ST_MATCHED;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_req_type) begin
                        o_cmd.read_start = 1'b1;
                        n_state          = S_READ;
                    end else begin
                        o_cmd.sample = 1'b1;
                        if (i_stat.frame_end) begin
                            n_state = (i_stat.frame_bad || i_stat.frame_unasg) ?
                                      S_DROP : S_SEARCH;
                        end
                    end
                end
            end
            S_READ: begin
                o_cmd.asel = A_LATCH;
                if (out_free) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.status = i_stat.rd_hit ? ST_VALID : ST_EMPTY;
                    n_state      = S_IDLE;
                end
            end
            S_DROP: begin
                if (out_free) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.status = i_stat.key_bad ? ST_BAD_MULT : ST_UNASSIGNED;
                    n_state      = S_IDLE;
                end
            end
            S_SEARCH: begin
                o_cmd.asel   = A_ISSUE;
                o_cmd.search = 1'b1;
                if (i_stat.hit) begin
                    n_state = S_MATCH;
                end else if (i_stat.exhausted) begin
                    n_state = i_stat.full ? S_FULL : S_INSERT;
                end
            end
            S_MATCH: begin
                o_cmd.asel = A_HIT;
                if (out_free) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.status = ST_MATCHED;
                    o_cmd.wr_hit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_INSERT: begin
                if (out_free) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.status = ST_INSERTED;
                    o_cmd.wr_new = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_FULL: begin
                if (out_free) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.status = ST_FULL;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/dch_dp.sv =====
// ----------------------------------------------------------------------------
// Dihedral histogram datapath
// Configuration, frame assembly, cluster table memories and result register.
// ----------------------------------------------------------------------------
`include "dihedral_conformation_histogram_assert.svh"

module dch_dp import dch_pkg::*; #(
    parameter int MAX_DIHEDRALS = 8,
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFGI_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic [ANGLE_W-1:0]  i_angle,
    input  logic [ANGLE_W-1:0]  i_phase,
    input  logic [MULT_W-1:0]   i_multiplicity,
    input  logic [EIDX_W-1:0]   i_entry_index,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    output logic [STAT_W-1:0]   o_status,
    output logic [OIDX_W-1:0]   o_cluster_index,
    output logic [FREQ_W-1:0]   o_frequency,
    output logic [OCODE_W-1:0]  o_minima_code,
    output logic [USED_W-1:0]   o_used_entries
);

    localparam int POS_W  = (MAX_DIHEDRALS > 1) ? $clog2(MAX_DIHEDRALS) : 1;
    localparam int CODE_W = DIGIT_W * MAX_DIHEDRALS;
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int NDB_W  = $clog2(MAX_DIHEDRALS + 1);
    localparam int ND_W   = (CFG_W > NDB_W) ? CFG_W : NDB_W;
    localparam int EX_W   = (IDX_W > EIDX_W) ? IDX_W : EIDX_W;
    localparam int CI_W   = (CNT_W > OIDX_W) ? CNT_W : OIDX_W;
    localparam int CMP_W  = (CNT_W > EIDX_W) ? CNT_W : EIDX_W;
    localparam int UX_W   = (CNT_W > USED_W) ? CNT_W : USED_W;
    localparam int CX_W   = (CODE_W > OCODE_W) ? CODE_W : OCODE_W;

    // configuration
    logic [CFG_W-1:0]  r_nd_cfg;
    logic [MULT_W-1:0] r_mult_ovr;

    // frame
    logic [POS_W-1:0]  r_pos;
    logic [CODE_W-1:0] r_code;
    logic              r_unasg;
    logic              r_bad;
    logic [CODE_W-1:0] r_key;
    logic              r_key_bad;

    // table
    logic [CODE_W-1:0] mem_code [TABLE_ENTRIES];
    logic [FREQ_W-1:0] mem_freq [TABLE_ENTRIES];
    logic [CODE_W-1:0] r_rd_code;
    logic [FREQ_W-1:0] r_rd_freq;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_issue;
    logic              r_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic [EIDX_W-1:0] r_ridx;

    // result
    logic [STAT_W-1:0]  r_o_status;
    logic [OIDX_W-1:0]  r_o_index;
    logic [FREQ_W-1:0]  r_o_freq;
    logic [OCODE_W-1:0] r_o_code;
    logic [USED_W-1:0]  r_o_used;

    logic [MULT_W-1:0]  m;
    logic               m_ok;
    logic [ANGLE_W-1:0] diff;
    logic [DIGIT_W-1:0] digit;
    logic               assigned;
    logic [ND_W-1:0]    nd_raw;
    logic [ND_W-1:0]    nd;
    logic [ND_W-1:0]    pos_inc;
    logic               frame_end;
    logic [CODE_W-1:0]  dig_sh;
    logic [CODE_W-1:0]  n_code;
    logic               n_unasg;
    logic               n_bad;
    logic               hit;
    logic               can_issue;
    logic               full;
    logic               rd_hit;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic [FREQ_W-1:0]  wr_freq;
    logic [FREQ_W-1:0]  inc_freq;
    logic [CNT_W-1:0]   count_inc;
    logic [EX_W-1:0]    in_idx_ext;
    logic [EX_W-1:0]    lat_idx_ext;
    logic [EX_W-1:0]    cmp_idx_ext;
    logic [CI_W-1:0]    cnt_idx_ext;
    logic [UX_W-1:0]    used_ext;
    logic [UX_W-1:0]    used_inc_ext;
    logic [CX_W-1:0]    key_ext;
    logic [CX_W-1:0]    rd_code_ext;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nd_cfg   <= CFG_W'(1);
            r_mult_ovr <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_NUM_DIHEDRALS: r_nd_cfg   <= i_cfg_data;
                REG_MULT_OVERRIDE: r_mult_ovr <= i_cfg_data[MULT_W-1:0];
                default: ;
            endcase
        end
    end

    // sample classification
    assign m    = (r_mult_ovr != '0) ? r_mult_ovr : i_multiplicity;
    assign m_ok = mult_valid(m);
    assign diff = i_angle - i_phase;

    dch_classify u_classify (
        .i_diff     (diff),
        .i_sel      (mult_sel(m)),
        .o_digit    (digit),
        .o_assigned (assigned)
    );

    assign nd_raw    = ND_W'(r_nd_cfg);
    assign nd        = (nd_raw == '0) ? ND_W'(1) :
                       ((nd_raw > ND_W'(MAX_DIHEDRALS)) ? ND_W'(MAX_DIHEDRALS) : nd_raw);
    assign pos_inc   = ND_W'(r_pos) + ND_W'(1);
    assign frame_end = (pos_inc >= nd);
    assign dig_sh    = CODE_W'(digit) << (DIGIT_W * r_pos);
    assign n_code    = r_code | ((m_ok && assigned) ? dig_sh : '0);
    assign n_unasg   = r_unasg | (m_ok && !assigned);
    assign n_bad     = r_bad | !m_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_code  <= '0;
            r_unasg <= 1'b0;
            r_bad   <= 1'b0;
        end else if (i_cmd.sample) begin
            if (frame_end) begin
                r_pos   <= '0;
                r_code  <= '0;
                r_unasg <= 1'b0;
                r_bad   <= 1'b0;
            end else begin
                r_pos   <= pos_inc[POS_W-1:0];
                r_code  <= n_code;
                r_unasg <= n_unasg;
                r_bad   <= n_bad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sample && frame_end) begin
            r_key     <= n_code;
            r_key_bad <= n_bad;
        end
        if (i_cmd.read_start) begin
            r_ridx <= i_entry_index;
        end
    end

    // table search
    assign hit       = r_cmp_vld && (r_rd_code == r_key);
    assign can_issue = (r_issue < r_count) && !hit;
    assign full      = (r_count == CNT_W'(TABLE_ENTRIES));
    assign rd_hit    = (CMP_W'(r_ridx) < CMP_W'(r_count));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue   <= '0;
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.sample) begin
            r_issue   <= '0;
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.search) begin
            if (can_issue) begin
                r_issue   <= r_issue + CNT_W'(1);
                r_cmp_vld <= 1'b1;
            end else if (!hit) begin
                r_cmp_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.search && can_issue) begin
            r_cmp_idx <= r_issue[IDX_W-1:0];
        end
    end

    assign in_idx_ext  = EX_W'(i_entry_index);
    assign lat_idx_ext = EX_W'(r_ridx);

    always_comb begin
        case (i_cmd.asel)
            A_INPUT: rd_addr = in_idx_ext[IDX_W-1:0];
            A_LATCH: rd_addr = lat_idx_ext[IDX_W-1:0];
            A_ISSUE: rd_addr = hit ? r_cmp_idx : r_issue[IDX_W-1:0];
            A_HIT:   rd_addr = r_cmp_idx;
            default: rd_addr = r_cmp_idx;
        endcase
    end

    assign inc_freq  = (&r_rd_freq) ? r_rd_freq : (r_rd_freq + FREQ_W'(1));
    assign wr_addr   = i_cmd.wr_new ? r_count[IDX_W-1:0] : r_cmp_idx;
    assign wr_freq   = i_cmd.wr_new ? FREQ_W'(1) : inc_freq;
    assign count_inc = r_count + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_new) begin
            mem_code[wr_addr] <= r_key;
        end
        if (i_cmd.wr_new || i_cmd.wr_hit) begin
            mem_freq[wr_addr] <= wr_freq;
        end
        r_rd_code <= mem_code[rd_addr];
        r_rd_freq <= mem_freq[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.wr_new) begin
            r_count <= count_inc;
        end
    end

    // result register
    assign cmp_idx_ext  = EX_W'(r_cmp_idx);
    assign cnt_idx_ext  = CI_W'(r_count);
    assign used_ext     = UX_W'(r_count);
    assign used_inc_ext = UX_W'(count_inc);
    assign key_ext      = CX_W'(r_key);
    assign rd_code_ext  = CX_W'(r_rd_code);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_status <= i_cmd.status;
            case (i_cmd.status)
                ST_MATCHED: begin
                    r_o_index <= cmp_idx_ext[OIDX_W-1:0];
                    r_o_freq  <= inc_freq;
                    r_o_code  <= key_ext[OCODE_W-1:0];
                    r_o_used  <= used_ext[USED_W-1:0];
                end
                ST_INSERTED: begin
                    r_o_index <= cnt_idx_ext[OIDX_W-1:0];
                    r_o_freq  <= FREQ_W'(1);
                    r_o_code  <= key_ext[OCODE_W-1:0];
                    r_o_used  <= used_inc_ext[USED_W-1:0];
                end
                ST_VALID: begin
                    r_o_index <= r_ridx;
                    r_o_freq  <= r_rd_freq;
                    r_o_code  <= rd_code_ext[OCODE_W-1:0];
                    r_o_used  <= used_ext[USED_W-1:0];
                end
                ST_EMPTY: begin
                    r_o_index <= r_ridx;
                    r_o_freq  <= '0;
                    r_o_code  <= '0;
                    r_o_used  <= used_ext[USED_W-1:0];
                end
                default: begin
                    r_o_index <= '0;
                    r_o_freq  <= '0;
                    r_o_code  <= key_ext[OCODE_W-1:0];
                    r_o_used  <= used_ext[USED_W-1:0];
                end
            endcase
        end
    end

    assign o_status        = r_o_status;
    assign o_cluster_index = r_o_index;
    assign o_frequency     = r_o_freq;
    assign o_minima_code   = r_o_code;
    assign o_used_entries  = r_o_used;

    assign o_stat.frame_end   = frame_end;
    assign o_stat.frame_bad   = n_bad;
    assign o_stat.frame_unasg = n_unasg;
    assign o_stat.key_bad     = r_key_bad;
    assign o_stat.rd_hit      = rd_hit;
    assign o_stat.hit         = hit;
    assign o_stat.exhausted   = !hit && !(r_issue < r_count);
    assign o_stat.full        = full;

    `DCH_ASSERT_IMP(a_insert_not_full, i_clk, i_rst_n, i_cmd.wr_new, !full, "insert into full table")
    `DCH_ASSERT_NXT(a_insert_counts, i_clk, i_rst_n, i_cmd.wr_new, r_count == CNT_W'($past(r_count) + 1'b1), "entry count not advanced on insert")
    `DCH_ASSERT_NXT(a_frame_restart, i_clk, i_rst_n, i_cmd.sample && frame_end, (r_pos == '0) && (r_code == '0), "frame not cleared at frame end")

endmodule
